/* src/wpb_pkg.sv */
// shared types, constants and helpers for the waveform peak binning unit
// no dependencies; imported by every module of the block except wpb_ram
`timescale 1ns / 1ps

package wpb_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_COLUMNS  = 1024;
    localparam int COL_W        = $clog2(MAX_COLUMNS);
    localparam int CH_CNT_W     = 4;
    localparam int COLS_CNT_W   = 11;
    localparam int FRAMES_W     = 32;
    localparam int PEAK_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int ABS_W        = SAMPLE_W + 1;
    localparam int SUM_W        = ABS_W + $clog2(MAX_CHANNELS);
    localparam int QUEUE_DEPTH  = 2;

    // request codes
    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_TOTAL_FRAMES  = 2'd1;
    localparam logic [1:0] CFG_COLUMN_COUNT  = 2'd2;

    // operation codes handed from front to back
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic [FRAMES_W-1:0]         frame_position;
        logic [COL_W-1:0]            read_column;
        logic signed [SAMPLE_W-1:0]  sample_ch0;
        logic signed [SAMPLE_W-1:0]  sample_ch1;
        logic signed [SAMPLE_W-1:0]  sample_ch2;
        logic signed [SAMPLE_W-1:0]  sample_ch3;
        logic signed [SAMPLE_W-1:0]  sample_ch4;
        logic signed [SAMPLE_W-1:0]  sample_ch5;
        logic signed [SAMPLE_W-1:0]  sample_ch6;
        logic signed [SAMPLE_W-1:0]  sample_ch7;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  column_index;
        logic [PEAK_W-1:0] peak_value;
        logic              status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        op;
        logic [COL_W-1:0]  column;
        logic [PEAK_W-1:0] peak;
        logic              status;
    } t_op;

    // configuration as the datapath sees it, channel and column counts clamped
    typedef struct packed {
        logic [CH_CNT_W-1:0]   chans;
        logic [COLS_CNT_W-1:0] cols;
        logic [FRAMES_W-1:0]   total;
    } t_cfg;

    function automatic logic [ABS_W-1:0] f_abs(input logic [SAMPLE_W-1:0] v);
        logic [ABS_W-1:0] ext;
        ext = {1'b0, v};
        if (v[SAMPLE_W-1]) begin
            return ABS_W'(1 << SAMPLE_W) - ext;
        end
        return ext;
    endfunction

endpackage

/* src/waveform_peak_binning_unit.sv */
// Waveform peak overview builder: one result per request, one request at a time
// in the front end. A frame request keeps the front end busy for a multiply step,
// 11 divider steps for the column and 20 for the channel average, all on one
// shared restoring divider, then a push that waits while the queue is full. The
// back end then pops it, reads the column peak and writes back the larger value,
// which becomes the result. Beyond-duration and unused requests give their result
// straight from the queue, reads after a ram read. A clear request sweeps all 1024
// ram entries, one per cycle, before its result. A stalled output holds results
// back. After reset the column ram is zeroed by the same sweep, during which
// o_in_stall stays high; configuration writes are taken at any time.
// depends on wpb_pkg, wpb_front, wpb_queue, wpb_back
`timescale 1ns / 1ps

module waveform_peak_binning_unit
    import wpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [FRAMES_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    logic [CH_CNT_W-1:0]   r_chan_cnt;
    logic [FRAMES_W-1:0]   r_total;
    logic [COLS_CNT_W-1:0] r_col_cnt;

    t_cfg cfg;
    logic init_busy;
    logic push;
    t_op  push_op;
    logic q_full;
    logic q_empty;
    logic pop;
    t_op  head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CH_CNT_W'(2);
            r_total    <= FRAMES_W'(1);
            r_col_cnt  <= COLS_CNT_W'(MAX_COLUMNS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data[CH_CNT_W-1:0];
                CFG_TOTAL_FRAMES:  r_total    <= i_cfg_data;
                CFG_COLUMN_COUNT:  r_col_cnt  <= i_cfg_data[COLS_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // for channel and column counts zero means one and large values saturate
    always_comb begin
        cfg.total = r_total;
        if (r_chan_cnt == '0) begin
            cfg.chans = CH_CNT_W'(1);
        end else if (r_chan_cnt > CH_CNT_W'(MAX_CHANNELS)) begin
            cfg.chans = CH_CNT_W'(MAX_CHANNELS);
        end else begin
            cfg.chans = r_chan_cnt;
        end
        if (r_col_cnt == '0) begin
            cfg.cols = COLS_CNT_W'(1);
        end else if (r_col_cnt > COLS_CNT_W'(MAX_COLUMNS)) begin
            cfg.cols = COLS_CNT_W'(MAX_COLUMNS);
        end else begin
            cfg.cols = r_col_cnt;
        end
    end

    wpb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_hold     (init_busy),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_push_op  (push_op),
        .i_q_full   (q_full)
    );

    wpb_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .i_pop     (pop),
        .o_empty   (q_empty),
        .o_head    (head)
    );

    wpb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_no_request_during_init: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> o_in_stall
    ) else $error("request accepted while column ram is being zeroed");

    a_peak_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !init_busy) |-> (o_out_item.peak_value <= PEAK_W'(32768))
    ) else $error("peak value above full scale");

    a_late_frame_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status)
            |-> (o_out_item.column_index == '0 && o_out_item.peak_value == '0)
    ) else $error("late frame result carries column or peak");

    a_no_pop_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty
    ) else $error("back end popped an empty queue");

endmodule

/* src/wpb_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module wpb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/wpb_queue.sv */
// short fifo of decoded operations between front and back
// depends on wpb_pkg
`timescale 1ns / 1ps

module wpb_queue
    import wpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

/* src/wpb_front.sv */
// front end: accepts requests, classifies them, computes column and frame peak
// with one shared restoring divider; depends on wpb_pkg
`timescale 1ns / 1ps

module wpb_front
    import wpb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_hold,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_push,
    output t_op      o_push_op,
    input  logic     i_q_full
);

    localparam int PROD_W = FRAMES_W + COLS_CNT_W;
    localparam int DVD_W  = SUM_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;

    logic [2:0]          r_state, n_state;
    logic                r_phase, n_phase;
    t_in_item            r_item, n_item;
    t_op                 r_op, n_op;
    logic [FRAMES_W-1:0] r_rem, n_rem;
    logic [FRAMES_W-1:0] r_den, n_den;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [DVD_W-1:0]    r_q, n_q;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SUM_W-1:0]    r_sum, n_sum;

    logic [SAMPLE_W-1:0] samples [MAX_CHANNELS];
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;
    logic [FRAMES_W:0]   trial;
    logic [FRAMES_W:0]   diff;
    logic                ge;
    logic [DVD_W-1:0]    q_next;

    assign o_in_stall = (r_state != S_IDLE) || i_hold;
    assign o_push     = (r_state == S_PUSH);
    assign o_push_op  = r_op;

    assign samples[0] = r_item.sample_ch0;
    assign samples[1] = r_item.sample_ch1;
    assign samples[2] = r_item.sample_ch2;
    assign samples[3] = r_item.sample_ch3;
    assign samples[4] = r_item.sample_ch4;
    assign samples[5] = r_item.sample_ch5;
    assign samples[6] = r_item.sample_ch6;
    assign samples[7] = r_item.sample_ch7;

    always_comb begin
        sum = '0;
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            if (CH_CNT_W'(ch) < i_cfg.chans) begin
                sum = sum + SUM_W'(f_abs(samples[ch]));
            end
        end
    end

    assign prod   = PROD_W'(r_item.frame_position) * PROD_W'(i_cfg.cols);
    assign trial  = {r_rem, r_dvd[DVD_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign diff   = trial - {1'b0, r_den};
    assign q_next = {r_q[DVD_W-2:0], ge};

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_item  = r_item;
        n_op    = r_op;
        n_rem   = r_rem;
        n_den   = r_den;
        n_dvd   = r_dvd;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_item      = i_in_item;
                    n_op.op     = OP_NONE;
                    n_op.column = '0;
                    n_op.peak   = '0;
                    n_op.status = 1'b0;
                    n_state     = S_PUSH;
                    case (i_in_item.req_type)
                        REQ_FRAME: begin
                            if (i_in_item.frame_position >= i_cfg.total) begin
                                n_op.status = 1'b1;
                            end else begin
                                n_op.op = OP_UPDATE;
                                n_state = S_MUL;
                            end
                        end
                        REQ_CLEAR: begin
                            n_op.op = OP_CLEAR;
                        end
                        REQ_READ: begin
                            n_op.column = i_in_item.read_column;
                            // out of range reads report zero without touching the ram
                            if ({1'b0, i_in_item.read_column} < i_cfg.cols) begin
                                n_op.op = OP_READ;
                            end
                        end
                        default: begin
                            n_op.op = OP_NONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                // quotient stays below the column count, so the top bits
                // of the product seed the partial remainder directly
                n_rem   = prod[PROD_W-1:COLS_CNT_W];
                n_dvd   = {prod[COLS_CNT_W-1:0], (DVD_W - COLS_CNT_W)'(0)};
                n_den   = i_cfg.total;
                n_cnt   = CNT_W'(COLS_CNT_W);
                n_q     = '0;
                n_phase = 1'b0;
                n_sum   = sum;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? diff[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                n_q   = q_next;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    if (!r_phase) begin
                        n_op.column = q_next[COL_W-1:0];
                        n_rem       = '0;
                        n_dvd       = r_sum;
                        n_den       = FRAMES_W'(i_cfg.chans);
                        n_cnt       = CNT_W'(DVD_W);
                        n_q         = '0;
                        n_phase     = 1'b1;
                    end else begin
                        n_op.peak = q_next[PEAK_W-1:0];
                        n_state   = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_op   <= n_op;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_dvd  <= n_dvd;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_sum  <= n_sum;
    end

endmodule

/* src/wpb_back.sv */
// back end: carries out queued operations on the column peak ram and
// holds the result register; depends on wpb_pkg and wpb_ram
`timescale 1ns / 1ps

module wpb_back
    import wpb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_op       i_head,
    output logic      o_pop,
    output logic      o_init_busy,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_MEM  = 3'd2;
    localparam logic [2:0] B_CLR  = 3'd3;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);

    logic [2:0]       r_state, n_state;
    logic [COL_W-1:0] r_sweep, n_sweep;
    t_op              r_cur, n_cur;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic              out_free;
    logic              emit;
    t_out_item         res;
    logic              we;
    logic [COL_W-1:0]  waddr;
    logic [PEAK_W-1:0] wdata;
    logic [PEAK_W-1:0] rdata;
    logic [PEAK_W-1:0] maxv;

    wpb_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_head.column),
        .o_rdata (rdata)
    );

    // only the back end fills the output register, so a free slot at pop
    // time stays free until this operation's result is ready
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == B_IDLE) && !i_q_empty && out_free;
    assign o_init_busy = (r_state == B_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign maxv        = (r_cur.peak > rdata) ? r_cur.peak : rdata;

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_cur   = r_cur;
        emit    = 1'b0;
        res     = '0;
        we      = 1'b0;
        waddr   = r_sweep;
        wdata   = '0;
        case (r_state)
            B_INIT: begin
                we      = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_COL) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (o_pop) begin
                    n_cur = i_head;
                    case (i_head.op)
                        OP_UPDATE, OP_READ: begin
                            n_state = B_MEM;
                        end
                        OP_CLEAR: begin
                            n_sweep = '0;
                            n_state = B_CLR;
                        end
                        default: begin
                            emit              = 1'b1;
                            res.column_index = i_head.column;
                            res.peak_value   = i_head.peak;
                            res.status       = i_head.status;
                        end
                    endcase
                end
            end
            B_MEM: begin
                emit             = 1'b1;
                res.column_index = r_cur.column;
                res.peak_value   = rdata;
                if (r_cur.op == OP_UPDATE) begin
                    we             = 1'b1;
                    waddr          = r_cur.column;
                    wdata          = maxv;
                    res.peak_value = maxv;
                end
                n_state = B_IDLE;
            end
            B_CLR: begin
                we      = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_COL) begin
                    emit    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign n_out_valid = emit || (r_out_valid && i_out_stall);
    assign n_out       = emit ? res : r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

endmodule
